FILE: design/czp_pkg.sv
package czp_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_BADSIG = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_byte;
    logic        encrypted;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [15:0] name_length;
    logic        last;
  } res_t;

  localparam logic [11:0] YEAR_BASE = 12'd1980;

  // result queue: four entries, room for two results beyond two held
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  // central directory signature 0x02014b50, little-endian byte order
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h50;
      2'd1: b = 8'h4B;
      2'd2: b = 8'h01;
      2'd3: b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/czp_core.sv
module czp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            restart,
  input  logic [15:0]     entry_total,
  output czp_pkg::res_t   res0,
  output czp_pkg::res_t   res1,
  output logic [1:0]      res_cnt
);
  import czp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_SKIP,
    PH_ERROR,
    PH_DONE
  } phase_t;

  localparam logic [5:0] OFF_SIG_LAST  = 6'd3;
  localparam logic [5:0] OFF_FLAGS     = 6'd8;
  localparam logic [5:0] OFF_TIME_LO   = 6'd12;
  localparam logic [5:0] OFF_TIME_HI   = 6'd13;
  localparam logic [5:0] OFF_DATE_LO   = 6'd14;
  localparam logic [5:0] OFF_DATE_HI   = 6'd15;
  localparam logic [5:0] OFF_NAME_LO   = 6'd28;
  localparam logic [5:0] OFF_NAME_HI   = 6'd29;
  localparam logic [5:0] OFF_EXTRA_LO  = 6'd30;
  localparam logic [5:0] OFF_EXTRA_HI  = 6'd31;
  localparam logic [5:0] OFF_CMT_LO    = 6'd32;
  localparam logic [5:0] OFF_CMT_HI    = 6'd33;
  localparam logic [5:0] OFF_HDR_LAST  = 6'd45;

  phase_t      phase_r, phase_nxt, c_phase;
  logic [5:0]  off_r, off_nxt, c_off;
  logic        bad_r, bad_nxt, c_bad;
  logic        flags_r, flags_nxt, c_flags;
  logic [15:0] time_r, time_nxt, c_time;
  logic [15:0] date_r, date_nxt, c_date;
  logic [15:0] nlen_r, nlen_nxt, c_nlen;
  logic [15:0] xlen_r, xlen_nxt, c_xlen;
  logic [15:0] clen_r, clen_nxt, c_clen;
  logic [16:0] rem_r, rem_nxt, c_rem;
  logic [15:0] seen_r, seen_nxt, c_seen;

  logic [16:0] rem_dec;
  logic [15:0] seen_inc;
  logic        skip_start;
  logic        fin;
  res_t        entry_res;
  res_t        done_res;
  res_t        res [2];
  logic [1:0]  n;

  // entry record from latched header fields
  always_comb begin
    entry_res             = '0;
    entry_res.kind        = KIND_ENTRY;
    entry_res.encrypted   = c_flags;
    entry_res.year        = 12'(c_date[15:9]) + YEAR_BASE;
    entry_res.month       = c_date[8:5];
    entry_res.day         = c_date[4:0];
    entry_res.hours       = c_time[15:11];
    entry_res.minutes     = c_time[10:5];
    entry_res.seconds     = {c_time[4:0], 1'b0};
    entry_res.name_length = c_nlen;
    done_res              = '0;
    done_res.kind         = KIND_DONE;
  end

  assign rem_dec  = c_rem - 17'((c_rem != 17'd0) ? 1 : 0);
  assign seen_inc = c_seen + 16'((c_seen != 16'hFFFF) ? 1 : 0);

  always_comb begin
    if (restart) begin
      c_phase = PH_HEADER;
      c_off   = '0;
      c_bad   = 1'b0;
      c_flags = 1'b0;
      c_time  = '0;
      c_date  = '0;
      c_nlen  = '0;
      c_xlen  = '0;
      c_clen  = '0;
      c_rem   = '0;
      c_seen  = '0;
    end else begin
      c_phase = phase_r;
      c_off   = off_r;
      c_bad   = bad_r;
      c_flags = flags_r;
      c_time  = time_r;
      c_date  = date_r;
      c_nlen  = nlen_r;
      c_xlen  = xlen_r;
      c_clen  = clen_r;
      c_rem   = rem_r;
      c_seen  = seen_r;
    end

    phase_nxt  = c_phase;
    off_nxt    = c_off;
    bad_nxt    = c_bad;
    flags_nxt  = c_flags;
    time_nxt   = c_time;
    date_nxt   = c_date;
    nlen_nxt   = c_nlen;
    xlen_nxt   = c_xlen;
    clen_nxt   = c_clen;
    rem_nxt    = c_rem;
    seen_nxt   = c_seen;
    res[0]     = '0;
    res[1]     = '0;
    n          = 2'd0;
    skip_start = 1'b0;
    fin        = 1'b0;

    unique case (c_phase)
      PH_HEADER: begin
        if (c_off == '0 && c_seen >= entry_total) begin
          res[0]    = done_res;
          n         = 2'd1;
          phase_nxt = PH_DONE;
        end else if (c_off == OFF_SIG_LAST &&
                     (c_bad || data_byte != sig_byte(c_off[1:0]))) begin
          res[0]      = '0;
          res[0].kind = KIND_BADSIG;
          n           = 2'd1;
          bad_nxt     = 1'b1;
          phase_nxt   = PH_ERROR;
        end else begin
          if (c_off < 6'd4 && data_byte != sig_byte(c_off[1:0])) begin
            bad_nxt = 1'b1;
          end
          unique case (c_off)
            OFF_FLAGS:    flags_nxt       = data_byte[0];
            OFF_TIME_LO:  time_nxt[7:0]   = data_byte;
            OFF_TIME_HI:  time_nxt[15:8]  = data_byte;
            OFF_DATE_LO:  date_nxt[7:0]   = data_byte;
            OFF_DATE_HI:  date_nxt[15:8]  = data_byte;
            OFF_NAME_LO:  nlen_nxt[7:0]   = data_byte;
            OFF_NAME_HI:  nlen_nxt[15:8]  = data_byte;
            OFF_EXTRA_LO: xlen_nxt[7:0]   = data_byte;
            OFF_EXTRA_HI: xlen_nxt[15:8]  = data_byte;
            OFF_CMT_LO:   clen_nxt[7:0]   = data_byte;
            OFF_CMT_HI:   clen_nxt[15:8]  = data_byte;
            default: ;
          endcase
          if (c_off != OFF_HDR_LAST) begin
            off_nxt = c_off + 6'd1;
          end else begin
            off_nxt = '0;
            if (c_nlen != '0) begin
              rem_nxt   = {1'b0, c_nlen};
              phase_nxt = PH_NAME;
            end else begin
              // empty name: record comes on the last header byte
              res[0]     = entry_res;
              n          = 2'd1;
              skip_start = 1'b1;
            end
          end
        end
      end
      PH_NAME: begin
        res[0]           = '0;
        res[0].kind      = KIND_NAME;
        res[0].name_byte = data_byte;
        n                = 2'd1;
        rem_nxt          = rem_dec;
        if (rem_dec == '0) begin
          res[1]     = entry_res;
          n          = 2'd2;
          skip_start = 1'b1;
        end
      end
      PH_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase

    if (skip_start) begin
      rem_nxt = {1'b0, c_xlen} + {1'b0, c_clen};
      if (c_xlen == '0 && c_clen == '0) begin
        fin = 1'b1;
      end else begin
        phase_nxt = PH_SKIP;
      end
    end

    if (fin) begin
      seen_nxt  = seen_inc;
      phase_nxt = PH_HEADER;
      off_nxt   = '0;
      bad_nxt   = 1'b0;
      // done rides along only if this byte has a free result slot
      if (seen_inc >= entry_total && n != 2'd2) begin
        res[n[0]] = done_res;
        n         = n + 2'd1;
        phase_nxt = PH_DONE;
      end
    end

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign res0    = res[0];
  assign res1    = res[1];
  assign res_cnt = take ? n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      off_r   <= '0;
      bad_r   <= 1'b0;
      flags_r <= 1'b0;
      time_r  <= '0;
      date_r  <= '0;
      nlen_r  <= '0;
      xlen_r  <= '0;
      clen_r  <= '0;
      rem_r   <= '0;
      seen_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      bad_r   <= bad_nxt;
      flags_r <= flags_nxt;
      time_r  <= time_nxt;
      date_r  <= date_nxt;
      nlen_r  <= nlen_nxt;
      xlen_r  <= xlen_nxt;
      clen_r  <= clen_nxt;
      rem_r   <= rem_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

FILE: design/czp_rq.sv
module czp_rq (
  input  logic            clk,
  input  logic            rst_n,
  input  czp_pkg::res_t   push0,
  input  czp_pkg::res_t   push1,
  input  logic [1:0]      push_cnt,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output czp_pkg::res_t   out_res
);
  import czp_pkg::*;

  res_t             mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r;
  logic [RQ_AW-1:0] rd_ptr_r;
  logic [RQ_AW:0]   cnt_r;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= (RQ_AW + 1)'(RQ_DEPTH - 2));
  assign out_res   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + RQ_AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RQ_AW'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + RQ_AW'(1);
      end
      cnt_r <= cnt_r + (RQ_AW + 1)'(push_cnt) - (RQ_AW + 1)'(pop);
    end
  end

endmodule

FILE: design/zip_central_directory_parser.sv
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_data_byte, in_restart
// out      output     out_valid/out_stall out_kind .. out_last (one result per item)
// cfg      input      cfg_valid/cfg_ready cfg_entry_total
//
// one directory byte is taken per cycle while the queue has room; a byte that
// yields two results (last name byte plus entry record) pushes both at once
// path: input register, then parser logic into a four-deep result queue
// reset: rst_n synchronous, active low; clears parser state and entry_total
// in_stall rises when the input register is full and the result queue
// cannot take two more results; out_stall just holds the queue head
module zip_central_directory_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_name_byte,
  output logic        out_encrypted,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic [15:0] out_name_length,
  output logic        out_last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_entry_total
);
  import czp_pkg::*;

  // input register
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_restart_r;
  logic [15:0] entry_total_r;

  logic        room;
  logic        take;
  res_t        res0;
  res_t        res1;
  logic [1:0]  res_cnt;
  res_t        out_res;

  // parser works on the registered byte whenever the queue has room
  assign take      = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      entry_total_r <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (cfg_valid) begin
        entry_total_r <= cfg_entry_total;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r    <= in_data_byte;
      in_restart_r <= in_restart;
    end
  end

  czp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_byte_r),
    .restart     (in_restart_r),
    .entry_total (entry_total_r),
    .res0        (res0),
    .res1        (res1),
    .res_cnt     (res_cnt)
  );

  czp_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .push_cnt  (res_cnt),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_name_byte   = out_res.name_byte;
  assign out_encrypted   = out_res.encrypted;
  assign out_year        = out_res.year;
  assign out_month       = out_res.month;
  assign out_day         = out_res.day;
  assign out_hours       = out_res.hours;
  assign out_minutes     = out_res.minutes;
  assign out_seconds     = out_res.seconds;
  assign out_name_length = out_res.name_length;
  assign out_last        = out_res.last;

endmodule
